/* rtl/core/utf8v_pkg.sv */
package utf8v_pkg;

  localparam int unsigned CODE_W  = 21;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned LEN_W   = 8;

  // Request codes on req_type.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Overlong minimum classes.
  localparam logic [1:0] MIN_NONE = 2'd0;
  localparam logic [1:0] MIN_2B   = 2'd1;
  localparam logic [1:0] MIN_3B   = 2'd2;
  localparam logic [1:0] MIN_4B   = 2'd3;

  localparam logic [CODE_W-1:0] CP_MIN_2B   = 21'h00080;
  localparam logic [CODE_W-1:0] CP_MIN_3B   = 21'h00800;
  localparam logic [CODE_W-1:0] CP_MIN_4B   = 21'h10000;
  localparam logic [CODE_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CODE_W-1:0] CP_SURR_LO  = 21'h0D800;
  localparam logic [CODE_W-1:0] CP_SURR_HI  = 21'h0DFFF;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 9'd511;
  localparam logic [LEN_W-1:0]   MAX_LENGTH_RST = 8'd192;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [1:0]         pending;
    logic [CODE_W-1:0]  code;
    logic [1:0]         min_class;
    logic               error;
    logic [COUNT_W-1:0] count;
  } utf8v_state_t;

  localparam utf8v_state_t STATE_CLEAR = '0;

endpackage

/* rtl/core/utf8v_decode.sv */
module utf8v_decode (
  input  utf8v_pkg::utf8v_state_t           cur,
  input  logic                              req_type,
  input  logic [7:0]                        data_byte,
  input  logic                              field_present,
  input  logic [utf8v_pkg::LEN_W-1:0]       max_length,
  output utf8v_pkg::utf8v_state_t           nxt,
  output logic                              verdict
);
  import utf8v_pkg::*;

  logic [CODE_W-1:0]  code_ext;
  logic [CODE_W-1:0]  class_min;
  logic [COUNT_W-1:0] count_inc;
  logic               bad_value;

  always_comb begin
    unique case (cur.min_class)
      MIN_2B:  class_min = CP_MIN_2B;
      MIN_3B:  class_min = CP_MIN_3B;
      MIN_4B:  class_min = CP_MIN_4B;
      default: class_min = '0;
    endcase
  end

  assign code_ext  = {cur.code[CODE_W-7:0], data_byte[5:0]};
  assign bad_value = (code_ext < class_min) || (code_ext > CP_MAX) ||
                     ((code_ext >= CP_SURR_LO) && (code_ext <= CP_SURR_HI));
  assign count_inc = (cur.count == COUNT_MAX) ? cur.count : cur.count + 1'b1;

  assign verdict = field_present && !cur.error && (cur.pending == 2'd0) &&
                   (cur.count <= {1'b0, max_length});

  always_comb begin
    nxt = cur;
    if (req_type == REQ_END) begin
      nxt = STATE_CLEAR;
    end else begin
      nxt.count = count_inc;
      if (cur.pending == 2'd0) begin
        if (!data_byte[7]) begin
          nxt.pending = 2'd0;
        end else if (data_byte[7:5] == 3'b110) begin
          nxt.pending   = 2'd1;
          nxt.code      = CODE_W'(data_byte[4:0]);
          nxt.min_class = MIN_2B;
        end else if (data_byte[7:4] == 4'b1110) begin
          nxt.pending   = 2'd2;
          nxt.code      = CODE_W'(data_byte[3:0]);
          nxt.min_class = MIN_3B;
        end else if (data_byte[7:3] == 5'b11110) begin
          nxt.pending   = 2'd3;
          nxt.code      = CODE_W'(data_byte[2:0]);
          nxt.min_class = MIN_4B;
        end else begin
          nxt.error = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        // A broken sequence is dropped and flagged; decoding restarts with no sequence open.
        nxt.error     = 1'b1;
        nxt.pending   = 2'd0;
        nxt.code      = '0;
        nxt.min_class = MIN_NONE;
      end else if (cur.pending == 2'd1) begin
        nxt.error     = cur.error | bad_value;
        nxt.pending   = 2'd0;
        nxt.code      = '0;
        nxt.min_class = MIN_NONE;
      end else begin
        nxt.pending = cur.pending - 2'd1;
        nxt.code    = code_ext;
      end
    end
  end

endmodule

/* rtl/core/utf8_string_validator.sv */
// UTF-8 string validator. A string arrives as a run of byte transfers
// (in_req_type = 0) closed by one end-marker transfer (in_req_type = 1);
// only the end marker produces a result, a single out_string_valid bit that
// is 1 when the string was well-formed UTF-8 (no bad lead or continuation
// byte, no overlong form, no surrogate, nothing above U+10FFFF, no sequence
// cut short), held no more than max_length bytes, and in_field_present was 1
// on the end marker. The end marker then clears all string state. The block
// takes one transfer per clock while in_stall is low: the input register feeds
// combinational decode logic whose state update closes in the same cycle, so
// byte after byte streams without gaps. out_valid rises once its end marker
// has passed into the result register. in_stall rises only when an end marker
// sits in the input register while the previous verdict is still held by
// out_stall. max_length is written through the cfg_ channel (always ready)
// and must only change between strings; it resets to 192.
module utf8_string_validator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_field_present,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_string_valid,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [utf8v_pkg::LEN_W-1:0] cfg_max_length
);
  import utf8v_pkg::*;

  // Input register.
  logic       stg_v_r;
  logic       stg_req_r;
  logic [7:0] stg_byte_r;
  logic       stg_present_r;

  // Decoder state and configuration.
  utf8v_state_t     st_r;
  utf8v_state_t     st_nxt;
  logic [LEN_W-1:0] max_length_r;

  // Result register.
  logic out_v_r;
  logic out_bit_r;

  logic verdict;
  logic advance;
  logic in_accept;

  // A byte always moves on; an end marker needs room in the result register.
  assign advance   = stg_v_r && ((stg_req_r == REQ_BYTE) || !out_v_r || !out_stall);
  assign in_stall  = stg_v_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_v_r;
  assign out_string_valid = out_bit_r;

  utf8v_decode u_decode (
    .cur           (st_r),
    .req_type      (stg_req_r),
    .data_byte     (stg_byte_r),
    .field_present (stg_present_r),
    .max_length    (max_length_r),
    .nxt           (st_nxt),
    .verdict       (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_accept) begin
      stg_v_r <= 1'b1;
    end else if (advance) begin
      stg_v_r <= 1'b0;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_req_r     <= in_req_type;
      stg_byte_r    <= in_data_byte;
      stg_present_r <= in_field_present;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_CLEAR;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_length_r <= cfg_max_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && (stg_req_r == REQ_END)) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (stg_req_r == REQ_END)) begin
      out_bit_r <= verdict;
    end
  end

endmodule

/* rtl/core/utf8v_checker.sv */
module utf8v_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_string_valid
);

  // The input side only backs up behind a held verdict.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result side was free");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A held verdict keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_string_valid)))
    else $error("stalled verdict changed or dropped");

endmodule

bind utf8_string_validator utf8v_checker u_utf8v_checker (.*);

/* tb/tb.sv */
// Testbench for the UTF-8 string validator.
//
// Strings are built as byte transfers followed by one end-marker transfer and
// are queued by the stimulus process in phases. A clocked driver feeds them to
// the block, one transfer at a time, with random gaps. Every transfer the block
// accepts also runs through a decoder model kept here, and each end marker
// leaves one expected verdict behind. A clocked monitor takes the verdicts
// with random stalls and compares each against the oldest expected one.
// The length limit is rewritten between phases, once the block has drained.
module tb;
  import utf8v_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // One transfer on the input channel.
  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic       present;
  } str_item_t;

  logic clk;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_req_type = REQ_BYTE;
  logic [7:0]       in_data_byte = 8'h00;
  logic             in_field_present = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_string_valid;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_max_length = MAX_LENGTH_RST;

  utf8_string_validator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_data_byte     (in_data_byte),
    .in_field_present (in_field_present),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_string_valid (out_string_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_length   (cfg_max_length)
  );

  // Transfers waiting to be driven, and verdicts the block still owes us.
  str_item_t byte_stream[$];
  logic      verdicts_due[$];
  int        items_queued = 0;
  int        mismatch_count = 0;
  int        cycles = 0;
  // Set for the last phase: no gaps on the input and no stalls on the output.
  bit        calm = 1'b0;

  // Decoder model state. The length limit mirrors the block's register.
  logic [1:0]         seq_left = '0;
  logic [CODE_W-1:0]  cp_acc = '0;
  logic [1:0]         cp_floor_cls = MIN_NONE;
  logic               str_bad = 1'b0;
  logic [COUNT_W-1:0] str_len = '0;
  logic [LEN_W-1:0]   len_limit = MAX_LENGTH_RST;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advances the decoder model by one accepted transfer. An end marker closes
  // the string: it records the verdict and clears everything but the limit.
  task automatic decode_step(input str_item_t it);
    logic [CODE_W-1:0] floor_cp;
    if (it.req == REQ_END) begin
      verdicts_due.push_back(it.present && !str_bad && seq_left == 2'd0 &&
                             str_len <= {1'b0, len_limit});
      seq_left = '0;
      cp_acc = '0;
      cp_floor_cls = MIN_NONE;
      str_bad = 1'b0;
      str_len = '0;
    end else begin
      // The byte count saturates instead of wrapping.
      if (str_len != COUNT_MAX) begin
        str_len = str_len + 1'b1;
      end
      if (seq_left == 2'd0) begin
        // Lead byte: ASCII passes, a multi-byte lead opens a sequence, and
        // anything else (a stray continuation or 0xF8 and up) is an error.
        casez (it.data)
          8'b0???????: ;
          8'b110?????: begin
            seq_left = 2'd1;
            cp_acc = {16'd0, it.data[4:0]};
            cp_floor_cls = MIN_2B;
          end
          8'b1110????: begin
            seq_left = 2'd2;
            cp_acc = {17'd0, it.data[3:0]};
            cp_floor_cls = MIN_3B;
          end
          8'b11110???: begin
            seq_left = 2'd3;
            cp_acc = {18'd0, it.data[2:0]};
            cp_floor_cls = MIN_4B;
          end
          default: str_bad = 1'b1;
        endcase
      end else if (it.data[7:6] != 2'b10) begin
        // A broken continuation drops the sequence; the byte is not reread
        // as a lead.
        str_bad = 1'b1;
        seq_left = '0;
        cp_acc = '0;
        cp_floor_cls = MIN_NONE;
      end else begin
        cp_acc = {cp_acc[CODE_W-7:0], it.data[5:0]};
        seq_left = seq_left - 1'b1;
        if (seq_left == 2'd0) begin
          case (cp_floor_cls)
            MIN_2B:  floor_cp = CP_MIN_2B;
            MIN_3B:  floor_cp = CP_MIN_3B;
            MIN_4B:  floor_cp = CP_MIN_4B;
            default: floor_cp = '0;
          endcase
          // Overlong forms, values past the top of the code space and
          // surrogates all spoil the string.
          if (cp_acc < floor_cp || cp_acc > CP_MAX ||
              (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI)) begin
            str_bad = 1'b1;
          end
          seq_left = '0;
          cp_acc = '0;
          cp_floor_cls = MIN_NONE;
        end
      end
    end
  endtask

  // Driver. A new transfer is presented only when the previous one has been
  // taken; while the block stalls, the payload holds still. Every signal gets
  // at most one nonblocking assignment per edge.
  str_item_t drv_item;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_step(drv_item);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_stream.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
          // Start a gap burst, this cycle included.
          gap_left = $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else if (byte_stream.size() != 0) begin
          drv_item = byte_stream.pop_front();
          in_valid <= 1'b1;
          in_req_type <= drv_item.req;
          in_data_byte <= drv_item.data;
          in_field_present <= drv_item.present;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. A verdict counts as transferred when out_valid is high and our
  // own stall is low at the edge.
  int  stall_left = 0;
  logic want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("string_valid: expected nothing, actual %0b", out_string_valid);
          mismatch_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_string_valid !== want) begin
            $error("string_valid: expected %0b, actual %0b", want, out_string_valid);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    str_item_t it;
    it.req = REQ_BYTE;
    it.data = b;
    it.present = 1'($urandom_range(0, 1));
    byte_stream.push_back(it);
    items_queued++;
  endtask

  task automatic queue_end(input logic present);
    str_item_t it;
    it.req = REQ_END;
    it.data = 8'($urandom_range(0, 255));
    it.present = present;
    byte_stream.push_back(it);
    items_queued++;
  endtask

  // Queues one encoded character. A broken character is one of: an overlong
  // form, a surrogate, a value above U+10FFFF, a bad lead byte or a bad
  // continuation byte. A cut character keeps its lead but loses at least its
  // last continuation byte.
  task automatic queue_char(input bit broken, input bit cut);
    logic [7:0]        enc[4];
    logic [CODE_W-1:0] cp;
    int                kind, cls, n, keep, bad_pos;
    kind = broken ? $urandom_range(1, 5) : 0;
    cls = (cut || kind == 1 || kind == 5) ? $urandom_range(1, 3) : $urandom_range(0, 3);
    case (cls)
      0: cp = CODE_W'($urandom_range(0, 'h7F));
      1: cp = CODE_W'($urandom_range('h80, 'h7FF));
      2: cp = CODE_W'($urandom_range('h800, 'hFFFF));
      default: cp = CODE_W'($urandom_range('h10000, 'h10FFFF));
    endcase
    // Keep clean three-byte characters out of the surrogate range.
    if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
      cp = cp ^ 21'h02000;
    end
    case (kind)
      1: cp = CODE_W'((cls == 1) ? $urandom_range(0, 'h7F) :
                      (cls == 2) ? $urandom_range(0, 'h7FF) : $urandom_range(0, 'hFFFF));
      2: begin
        cls = 2;
        cp = CODE_W'($urandom_range('hD800, 'hDFFF));
      end
      3: begin
        cls = 3;
        cp = CODE_W'($urandom_range('h110000, 'h1FFFFF));
      end
      4: begin
        queue_byte(8'($urandom_range(0, 1) ? $urandom_range('h80, 'hBF) :
                      $urandom_range('hF8, 'hFF)));
        return;
      end
      default: ;
    endcase
    case (cls)
      0: begin
        enc[0] = {1'b0, cp[6:0]};
        n = 1;
      end
      1: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
        n = 2;
      end
      2: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
        n = 3;
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
        n = 4;
      end
    endcase
    if (kind == 5) begin
      bad_pos = $urandom_range(1, n - 1);
      case ($urandom_range(0, 2))
        0: enc[bad_pos] = {2'b00, 6'($urandom_range(0, 63))};
        1: enc[bad_pos] = {2'b01, 6'($urandom_range(0, 63))};
        default: enc[bad_pos] = {2'b11, 6'($urandom_range(0, 63))};
      endcase
    end
    keep = cut ? $urandom_range(1, n - 1) : n;
    for (int i = 0; i < keep; i++) begin
      queue_byte(enc[i]);
    end
  endtask

  // Mostly well-formed strings with random characters; some carry faults,
  // a few are raw noise, and now and then the last character is cut short.
  task automatic queue_string();
    int style, nchars;
    style = $urandom_range(0, 9);
    nchars = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    if (style == 9) begin
      repeat (nchars) queue_byte(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < nchars; i++) begin
        queue_char(style >= 7 && $urandom_range(0, 4) == 0, 1'b0);
      end
      if ($urandom_range(0, 19) == 0) begin
        queue_char(1'b0, 1'b1);
      end
    end
    queue_end($urandom_range(0, 15) != 0);
  endtask

  task automatic queue_ascii_string(input int nbytes);
    repeat (nbytes) queue_byte(8'($urandom_range(0, 'h7F)));
    queue_end(1'b1);
  endtask

  // Waits until every queued transfer has been taken and every verdict has
  // come back, then lets the pipeline settle. Sampled on the falling edge so
  // the driver and monitor have finished their edge.
  task automatic wait_idle();
    do @(negedge clk);
    while (byte_stream.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    int target;
    target = items_queued + n;
    while (items_queued < target) begin
      queue_string();
    end
  endtask

  task automatic set_max_length(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_length <= v;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    len_limit = v;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings under the reset limit of 192 bytes.
    queue_end(1'b1);                       // empty string
    queue_end(1'b0);                       // field not present
    queue_byte(8'h00); queue_byte(8'h7F); queue_end(1'b1);
    queue_byte(8'hC1); queue_byte(8'hBF); queue_end(1'b1);        // overlong
    queue_byte(8'hED); queue_byte(8'hA0); queue_byte(8'h80);      // surrogate
    queue_end(1'b1);
    queue_byte(8'hF4); queue_byte(8'h90); queue_byte(8'h80);      // above U+10FFFF
    queue_byte(8'h80); queue_end(1'b1);
    queue_byte(8'hF8); queue_end(1'b1);                           // bad lead
    queue_byte(8'hE0); queue_byte(8'h41); queue_end(1'b1);        // bad continuation
    queue_byte(8'hF0); queue_byte(8'h9F); queue_end(1'b1);        // cut short
    queue_random(100);
    wait_idle();

    // Zero limit: only empty strings can pass.
    set_max_length(8'd0);
    queue_random(60);
    wait_idle();

    // Full limit: a string of exactly 255 bytes passes, and one long enough
    // to saturate the byte count must still fail.
    set_max_length(8'd255);
    queue_ascii_string(255);
    queue_ascii_string(520);
    queue_random(80);
    wait_idle();

    // Tight limits make the length check decide many verdicts.
    set_max_length(8'($urandom_range(1, 30)));
    queue_random(100);
    wait_idle();

    set_max_length(8'($urandom_range(0, 255)));
    queue_random(100);
    wait_idle();

    // Last phase runs back to back with no gaps and no stalls.
    set_max_length(8'($urandom_range(4, 40)));
    calm = 1'b1;
    queue_random(60);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
